// ===== rtl/core/hsso_pkg.sv =====
// Shared constants, register codes and divider handshake types for the sync saw oscillator.
package hsso_pkg;

    localparam int WORD_W      = 32;
    localparam int DEN_W       = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRIG_OFS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_START   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_STEP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_ENABLE  = 3'd5;

    localparam logic [WORD_W-1:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] DEN_ROUND     = 32'd65535;
    localparam logic [WORD_W-1:0] RESTART_ONE   = 32'd1;
    localparam int                RESTART_SHIFT = 17;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/core/hsso_div.sv =====
// Bit-serial restoring divider producing the master reciprocal, half turn over a 16-bit divisor.
module hsso_div (
    input  logic              clk,
    input  logic              rst_n,
    input  hsso_pkg::div_req_t req,
    output hsso_pkg::div_rsp_t rsp
);
    import hsso_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [WORD_W-1:0] quo_reg, quo_next;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] rem_diff;
    logic           fits;

    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = HALF_TURN;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (den_reg == '0) ? '1 : quo_reg;

endmodule

// ===== rtl/core/hard_sync_saw_oscillator_unit.sv =====
// Top level of the hard-synced sawtooth oscillator with ramped gain and mixing.
//
// Usage: write the six registers over the cfg channel (index, data) while the block
// is idle; cfg_ready is always high. Each input transaction (in_valid/in_ready)
// carries one sample slot: mix_in, a load flag with start phases, and final_sample.
// Each one yields exactly one output transaction (out_valid/out_ready) with the
// rendered sample, the new slave phase and buffer_done.
// Sequencing: one item at a time through a single shared 32x32 signed multiplier and
// a small sequencer. A load first waits in S_DIV while the bit-serial divider forms
// the reciprocal (one quotient bit per cycle). Each item then advances the phases
// (S_ADV); when the master wraps, two chained multiplies form the restart position
// (S_MUL1, S_MUL2, S_RESTART); S_GAIN forms the raw saw, or with gain enabled ramps
// the gain for S_MULG and S_MIX to mix in; the result then goes out (S_OUT). It sits in an
// output register, so the next transaction is accepted while a result still waits
// for out_ready. If the receiver still stalls when the next result is finished, the
// sequencer holds it until the output register frees.
// Reset: the configuration registers, phases, gain and reciprocal clear to zero; no output pending.
module hard_sync_saw_oscillator_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hsso_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hsso_pkg::WORD_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [hsso_pkg::WORD_W-1:0]    mix_in,
    input  logic                                  load,
    input  logic [hsso_pkg::WORD_W-1:0]           start_phase,
    input  logic [hsso_pkg::WORD_W-1:0]           start_master_phase,
    input  logic                                  final_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [hsso_pkg::WORD_W-1:0]    sample_out,
    output logic [hsso_pkg::WORD_W-1:0]           phase_out,
    output logic                                  buffer_done
);
    import hsso_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] S_DIV     = 4'd1;
    localparam logic [ST_W-1:0] S_ADV     = 4'd2;
    localparam logic [ST_W-1:0] S_MUL1    = 4'd3;
    localparam logic [ST_W-1:0] S_MUL2    = 4'd4;
    localparam logic [ST_W-1:0] S_RESTART = 4'd5;
    localparam logic [ST_W-1:0] S_GAIN    = 4'd6;
    localparam logic [ST_W-1:0] S_MULG    = 4'd7;
    localparam logic [ST_W-1:0] S_MIX     = 4'd8;
    localparam logic [ST_W-1:0] S_OUT     = 4'd9;

    logic [ST_W-1:0] state_reg, state_next;

    logic [WORD_W-1:0] phase_step_reg;
    logic [WORD_W-1:0] master_step_reg;
    logic [WORD_W-1:0] retrig_reg;
    logic [WORD_W-1:0] gain_start_reg;
    logic [WORD_W-1:0] gain_step_reg;
    logic              gain_en_reg;

    logic [WORD_W-1:0] slave_reg, slave_next;
    logic [WORD_W-1:0] master_reg, master_next;
    logic [WORD_W-1:0] gain_reg, gain_next;
    logic [WORD_W-1:0] recip_reg, recip_next;

    logic [WORD_W-1:0] mix_reg;
    logic              load_reg;
    logic [WORD_W-1:0] start_reg;
    logic [WORD_W-1:0] start_master_reg;
    logic              final_reg;

    logic [WORD_W-1:0] res_reg, res_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_sample_reg, out_sample_next;
    logic [WORD_W-1:0] out_phase_reg, out_phase_next;
    logic              out_done_reg, out_done_next;

    logic signed [WORD_W-1:0]   mul_a, mul_b;
    logic signed [2*WORD_W-1:0] prod_reg;

    logic [WORD_W-1:0] den_sum;
    logic [WORD_W-1:0] base_slave, base_master;
    logic [WORD_W-1:0] adv_slave, adv_master;
    logic              in_fire;
    logic              out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    hsso_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign den_sum       = master_step_reg + DEN_ROUND;
    assign div_req.start = in_fire && load;
    assign div_req.den   = den_sum[WORD_W-1:WORD_W-DEN_W];

    assign base_slave  = load_reg ? start_reg : slave_reg;
    assign base_master = load_reg ? start_master_reg : master_reg;
    assign adv_slave   = base_slave + phase_step_reg;
    assign adv_master  = base_master + master_step_reg;

    always_comb
    begin
        case (state_reg)
            S_MUL1:
            begin
                mul_a = master_reg;
                mul_b = phase_step_reg;
            end
            S_MUL2:
            begin
                mul_a = prod_reg[2*WORD_W-1:WORD_W];
                mul_b = recip_reg;
            end
            default:
            begin
                mul_a = slave_reg;
                mul_b = gain_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        slave_next      = slave_reg;
        master_next     = master_reg;
        gain_next       = gain_reg;
        recip_next      = recip_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        out_phase_next  = out_phase_reg;
        out_done_next   = out_done_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = load ? S_DIV : S_ADV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    recip_next = div_rsp.quo;
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                slave_next  = adv_slave;
                master_next = adv_master;
                if (load_reg)
                begin
                    gain_next = gain_start_reg;
                end
                state_next = (adv_master < master_step_reg) ? S_MUL1 : S_GAIN;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_RESTART;
            end
            S_RESTART:
            begin
                slave_next = (prod_reg[2*WORD_W-1:WORD_W] << RESTART_SHIFT)
                           + RESTART_ONE + retrig_reg + HALF_TURN;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (gain_en_reg)
                begin
                    gain_next  = gain_reg + gain_step_reg;
                    state_next = S_MULG;
                end
                else
                begin
                    res_next   = {slave_reg[WORD_W-1], slave_reg[WORD_W-1:1]};
                    state_next = S_OUT;
                end
            end
            S_MULG:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                res_next   = mix_reg + prod_reg[2*WORD_W-1:WORD_W]
                           + {{(WORD_W-1){1'b0}}, prod_reg[WORD_W-1]};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_reg;
                    out_phase_next  = slave_reg;
                    out_done_next   = final_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_step_reg  <= '0;
            master_step_reg <= '0;
            retrig_reg      <= '0;
            gain_start_reg  <= '0;
            gain_step_reg   <= '0;
            gain_en_reg     <= 1'b0;
            slave_reg       <= '0;
            master_reg      <= '0;
            gain_reg        <= '0;
            recip_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slave_reg     <= slave_next;
            master_reg    <= master_next;
            gain_reg      <= gain_next;
            recip_reg     <= recip_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:  phase_step_reg  <= cfg_data;
                    REG_MASTER_STEP: master_step_reg <= cfg_data;
                    REG_RETRIG_OFS:  retrig_reg      <= cfg_data;
                    REG_GAIN_START:  gain_start_reg  <= cfg_data;
                    REG_GAIN_STEP:   gain_step_reg   <= cfg_data;
                    REG_GAIN_ENABLE: gain_en_reg     <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= mul_a * mul_b;
        res_reg        <= res_next;
        out_sample_reg <= out_sample_next;
        out_phase_reg  <= out_phase_next;
        out_done_reg   <= out_done_next;
        if (in_fire)
        begin
            mix_reg          <= mix_in;
            load_reg         <= load;
            start_reg        <= start_phase;
            start_master_reg <= start_master_phase;
            final_reg        <= final_sample;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = out_sample_reg;
    assign phase_out   = out_phase_reg;
    assign buffer_done = out_done_reg;

endmodule

// ===== rtl/core/hsso_checker.sv =====
// Port-level checker for the sync saw oscillator, bound to the top level.
module hsso_port_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [hsso_pkg::WORD_W-1:0]        sample_out,
    input logic [hsso_pkg::WORD_W-1:0]        phase_out,
    input logic                               buffer_done
);
    import hsso_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous transaction in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)
                                       && $stable(phase_out) && $stable(buffer_done)))
        else $error("stalled output transaction changed");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a transaction in progress");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("sequencer finished without presenting a result");

endmodule

bind hard_sync_saw_oscillator_unit hsso_port_checker u_hsso_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .phase_out   (phase_out),
    .buffer_done (buffer_done)
);

// ===== tb/hsso_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sync saw oscillator: mirrors its registers, predicts every sample and compares.
module hsso_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [hsso_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hsso_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [hsso_pkg::WORD_W-1:0]  mix_in,
    input  logic                                load,
    input  logic [hsso_pkg::WORD_W-1:0]         start_phase,
    input  logic [hsso_pkg::WORD_W-1:0]         start_master_phase,
    input  logic                                final_sample,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [hsso_pkg::WORD_W-1:0]  sample_out,
    input  logic [hsso_pkg::WORD_W-1:0]         phase_out,
    input  logic                                buffer_done,
    output int                                  mismatch_count,
    output int                                  pending_count
);
    import hsso_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] sample;
        logic [WORD_W-1:0] phase;
        logic              done;
    } render_t;

    logic [WORD_W-1:0] step_slave;
    logic [WORD_W-1:0] step_master;
    logic [WORD_W-1:0] retrig_ofs;
    logic [WORD_W-1:0] gain_init;
    logic [WORD_W-1:0] gain_incr;
    logic              gain_on;

    logic [WORD_W-1:0] slave_ph;
    logic [WORD_W-1:0] master_ph;
    logic [WORD_W-1:0] gain_cur;
    logic [WORD_W-1:0] master_recip;

    render_t           render_q[$];
    int                bad = 0;

    // upper word of the signed 32x32 product plus a rounding term
    function automatic logic [WORD_W-1:0] upper_word(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b,
                                                    input logic [63:0] rnd);
        logic signed [63:0] prod;
        logic [63:0]        acc;
        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        acc  = prod + rnd;
        return acc[63:32];
    endfunction

    function automatic render_t render_sample(input logic [WORD_W-1:0] mix,
                                              input logic ld,
                                              input logic [WORD_W-1:0] sp,
                                              input logic [WORD_W-1:0] mp,
                                              input logic fin);
        render_t           r;
        logic [WORD_W-1:0] rounded;
        logic [WORD_W-1:0] overshoot;
        logic [WORD_W-1:0] frac;
        logic [DEN_W-1:0]  den;
        rounded = step_master + DEN_ROUND;
        den     = rounded[WORD_W-1 -: DEN_W];
        if (ld)
        begin
            slave_ph     = sp;
            master_ph    = mp;
            gain_cur     = gain_init;
            master_recip = (den == '0) ? '1 : HALF_TURN / {{(WORD_W-DEN_W){1'b0}}, den};
        end
        slave_ph  = slave_ph + step_slave;
        master_ph = master_ph + step_master;
        if (master_ph < step_master)
        begin
            overshoot = upper_word(master_ph, step_slave, '0);
            frac      = upper_word(overshoot, master_recip, '0);
            slave_ph  = (frac << RESTART_SHIFT) + RESTART_ONE + retrig_ofs + HALF_TURN;
        end
        if (gain_on)
        begin
            gain_cur = gain_cur + gain_incr;
            r.sample = mix + upper_word(slave_ph, gain_cur, {32'b0, HALF_TURN});
        end
        else
        begin
            r.sample = {slave_ph[31], slave_ph[31:1]};
        end
        r.phase = slave_ph;
        r.done  = fin;
        return r;
    endfunction

    task automatic note_field(input string what, input logic [WORD_W-1:0] want_v,
                              input logic [WORD_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            bad++;
            $display("%0t ns: %s expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : watch
        render_t want;
        if (!rst_n)
        begin
            step_slave   = '0;
            step_master  = '0;
            retrig_ofs   = '0;
            gain_init    = '0;
            gain_incr    = '0;
            gain_on      = 1'b0;
            slave_ph     = '0;
            master_ph    = '0;
            gain_cur     = '0;
            master_recip = '0;
            render_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:  step_slave  = cfg_data;
                    REG_MASTER_STEP: step_master = cfg_data;
                    REG_RETRIG_OFS:  retrig_ofs  = cfg_data;
                    REG_GAIN_START:  gain_init   = cfg_data;
                    REG_GAIN_STEP:   gain_incr   = cfg_data;
                    REG_GAIN_ENABLE: gain_on     = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (render_q.size() == 0)
                begin
                    bad++;
                    $display("%0t ns: transaction expected none, got sample %h phase %h",
                             $time, sample_out, phase_out);
                end
                else
                begin
                    want = render_q.pop_front();
                    note_field("sample_out", want.sample, sample_out);
                    note_field("phase_out", want.phase, phase_out);
                    note_field("buffer_done", {31'b0, want.done}, {31'b0, buffer_done});
                end
            end
            if (in_valid && in_ready)
                render_q.push_back(render_sample(mix_in, load, start_phase,
                                                 start_master_phase, final_sample));
        end
        mismatch_count <= bad;
        pending_count  <= render_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the sync saw oscillator testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
    import hsso_pkg::*;

    localparam int SLOT_TARGET = 1450;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                      clk                = 1'b0;
    logic                      rst_n              = 1'b0;
    logic                      cfg_valid          = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index          = '0;
    logic [WORD_W-1:0]         cfg_data           = '0;
    logic                      in_valid           = 1'b0;
    logic signed [WORD_W-1:0]  mix_in             = '0;
    logic                      load               = 1'b0;
    logic [WORD_W-1:0]         start_phase        = '0;
    logic [WORD_W-1:0]         start_master_phase = '0;
    logic                      final_sample       = 1'b0;
    logic                      out_ready          = 1'b0;

    logic                      cfg_ready;
    logic                      in_ready;
    logic                      out_valid;
    logic signed [WORD_W-1:0]  sample_out;
    logic [WORD_W-1:0]         phase_out;
    logic                      buffer_done;

    int mismatch_count;
    int pending_count;
    int cycle_cnt     = 0;
    int slots_sent    = 0;
    int buffers_sent  = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int rx_hold       = 0;
    int rx_mode       = 0;

    always #4 clk = ~clk;

    hard_sync_saw_oscillator_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mix_in             (mix_in),
        .load               (load),
        .start_phase        (start_phase),
        .start_master_phase (start_master_phase),
        .final_sample       (final_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .sample_out         (sample_out),
        .phase_out          (phase_out),
        .buffer_done        (buffer_done)
    );

    hsso_checker chk (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mix_in             (mix_in),
        .load               (load),
        .start_phase        (start_phase),
        .start_master_phase (start_master_phase),
        .final_sample       (final_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .sample_out         (sample_out),
        .phase_out          (phase_out),
        .buffer_done        (buffer_done),
        .mismatch_count     (mismatch_count),
        .pending_count      (pending_count)
    );

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_mode != 0 && $urandom_range(0, 5) == 0)
                rx_hold <= (rx_mode == 2) ? $urandom_range(4, 20) : $urandom_range(1, 3);
        end
        if ($urandom_range(0, 199) == 0)
            rx_mode <= $urandom_range(0, 2);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_master();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom_range(32'hFFFF_0001, 32'hFFFF_FFFF);
            2:       return $urandom_range(1, 32'h0001_0000);
            3:       return $urandom;
            default: return $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [WORD_W-1:0] ps, input logic [WORD_W-1:0] ms,
                                input logic [WORD_W-1:0] ro, input logic [WORD_W-1:0] gs,
                                input logic [WORD_W-1:0] gi, input logic ge);
        write_reg(REG_PHASE_STEP, ps);
        write_reg(REG_MASTER_STEP, ms);
        write_reg(REG_RETRIG_OFS, ro);
        write_reg(REG_GAIN_START, gs);
        write_reg(REG_GAIN_STEP, gi);
        write_reg(REG_GAIN_ENABLE, {31'b0, ge});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // drop valid and wait for every outstanding sample to come back
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic send_slot(input logic [WORD_W-1:0] mix, input logic ld,
                             input logic [WORD_W-1:0] sp, input logic [WORD_W-1:0] smp,
                             input logic fin);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6))
                @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid           <= 1'b1;
        mix_in             <= mix;
        load               <= ld;
        start_phase        <= sp;
        start_master_phase <= smp;
        final_sample       <= fin;
        do @(posedge clk); while (!in_ready);
        slots_sent++;
    endtask

    task automatic send_buffer(input int len, input bit noisy);
        logic ld;
        logic fin;
        for (int i = 0; i < len; i++)
        begin
            ld  = (i == 0);
            fin = (i == len - 1);
            if (noisy)
            begin
                ld  = ($urandom_range(0, 4) == 0);
                fin = ($urandom_range(0, 4) == 0);
            end
            send_slot($urandom, ld, $urandom, $urandom, fin);
        end
        buffers_sent++;
    endtask

    initial
    begin : stimulus
        int  len;
        bit  noisy;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: zero master step, zero divisor
        send_slot(32'h7FFF_FFFF, 1'b0, '1, '1, 1'b0);
        send_slot(32'h8000_0000, 1'b1, '1, '1, 1'b1);
        quiesce();

        // wrapping divisor, extreme gains and offsets
        program_regs(32'h7FFF_FFFF, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_slot(32'h7FFF_FFFF, 1'b1, '0, '0, 1'b0);
        send_slot(32'h8000_0000, 1'b0, '1, '1, 1'b0);
        send_slot('0, 1'b1, '1, '1, 1'b0);
        send_slot(32'h8000_0000, 1'b0, '0, '0, 1'b1);
        quiesce();

        // smallest divisor, raw saw
        program_regs('1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_slot('0, 1'b1, '0, '1, 1'b0);
        send_slot('1, 1'b0, '0, '0, 1'b0);
        send_slot('0, 1'b0, '1, '1, 1'b1);
        quiesce();

        program_regs(32'h0123_4567, 32'h0001_0000, 32'h0000_1000, 32'h4000_0000,
                     32'hFFFF_F000, 1'b1);
        send_slot(32'h1234_5678, 1'b1, 32'hC000_0000, 32'hFFFF_8000, 1'b0);
        send_slot(32'hEDCB_A987, 1'b0, '0, '0, 1'b0);
        send_slot(32'h0000_0001, 1'b0, '0, '0, 1'b0);
        send_slot(32'hFFFF_FFFF, 1'b0, '0, '0, 1'b1);
        quiesce();

        // new master step without a load: reciprocal stays stale
        program_regs(32'h0123_4567, 32'h4000_0000, 32'h0000_1000, 32'h4000_0000,
                     32'hFFFF_F000, 1'b1);
        send_slot(32'h5555_5555, 1'b0, '0, '0, 1'b0);
        send_slot(32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0);
        send_slot(32'h0F0F_0F0F, 1'b0, '0, '0, 1'b1);

        while (slots_sent < SLOT_TARGET)
        begin
            quiesce();
            program_regs(pick_word(), pick_master(), pick_word(), pick_word(), pick_word(),
                         $urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 4))
            begin
                noisy = ($urandom_range(0, 6) == 0);
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 24);
                send_buffer(len, noisy);
            end
        end

        quiesce();
        repeat (48) @(posedge clk);
        $display("covered %0d samples in %0d buffers over %0d register settings,",
                 slots_sent, buffers_sent, settings_used);
        $display("with sender gaps and receiver stalls throughout");
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hsso_pkg.sv
rtl/core/hsso_div.sv
rtl/core/hard_sync_saw_oscillator_unit.sv
rtl/core/hsso_checker.sv
tb/hsso_checker.sv
tb/tb_top.sv
